// File: hdl/msq_pkg.sv
package msq_pkg;

    // Default parameter values
    localparam int TABLE_DEPTH_DEF  = 64;
    localparam int TICK_FREQ_HZ_DEF = 1000000;

    // Queue depths between the parts of the block
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    // Input mode codes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Tone programming constants
    localparam logic [15:0] FULL_DRIVE_FREQ   = 16'hFFFF;
    localparam logic [19:0] FULL_DRIVE_RELOAD = 20'd199;
    localparam logic [19:0] RELOAD_MAX        = 20'hFFFFF;

    // floor(x/5) == (x * DIV5_MUL) >> DIV5_SHIFT for any 20-bit x
    localparam logic [19:0] DIV5_MUL   = 20'hCCCCD;
    localparam int          DIV5_SHIFT = 22;

    // One input transaction
    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  entry_index;
        logic [15:0] tone_freq;
        logic [15:0] tone_duration;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [19:0] pwm_reload;
        logic [19:0] pwm_compare;
        logic        playing;
        logic [5:0]  current_index;
    } t_result;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_NOP,
        OP_WRITE,
        OP_START,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [5:0]  entry_index;
        logic [15:0] tone_freq;
        logic [15:0] tone_duration;
    } t_cmd;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_DIV,
        S_SCALE,
        S_DUTY,
        S_EMIT
    } t_state;

endpackage

// File: hdl/melody_tone_sequencer_unit.sv
// Melody tone sequencer: drives the reload and compare of a PWM tone generator
// from a table of (frequency, duration) entries.
// Input channel: queue-style push/full carrying i_item. Mode 0 writes a table
// entry, mode 1 starts playback at an entry (ignored while enable is 0),
// mode 2 is one timer tick. Every input transaction yields exactly one result.
// Result channel: queue-style empty/pop; o_result shows reload, compare,
// playing flag and current entry after that transaction's update.
// Configuration: i_cfg_we/i_cfg_wdata write the enable bit; write it only
// while the block has no transaction in flight.
// Path from the accepting edge to empty going low: the command queue, then
// S_IDLE, S_DECODE, S_EMIT and the result queue for a table write, a tick that
// stays on its tone or a no-op; a new entry adds S_LOAD (one table read); a
// tone that needs a reload adds the bit-serial divider (a load step, then one
// quotient bit per cycle, clog2(TICK_FREQ_HZ+1) bits, 20 at 1 MHz) and S_SCALE
// and S_DUTY. The back-end sequencer works one transaction at a time.
// A two-entry queue sits in front of the sequencer and another behind it; when
// pop is held low, results collect there, then the sequencer and in turn the
// input side stall (full rises). Nothing is dropped.
// Reset: enable 0, not playing, entry 0, reload 199, compare 0, queues empty.
// Table entries hold no reset value and must be written before use.
module melody_tone_sequencer_unit #(
    parameter int TABLE_DEPTH  = msq_pkg::TABLE_DEPTH_DEF,
    parameter int TICK_FREQ_HZ = msq_pkg::TICK_FREQ_HZ_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  msq_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output msq_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata
);

    import msq_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int DW = $clog2(TICK_FREQ_HZ + 1);
    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    t_cmd             front_cmd;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_rdata;
    t_cmd             cmd_head;

    logic             ram_we;
    logic [PW-1:0]    ram_waddr;
    logic [31:0]      ram_wdata;
    logic [PW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;

    logic             div_start;
    logic [15:0]      div_divisor;
    logic             div_done;
    logic [DW-1:0]    div_quotient;

    t_result          back_res;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_rdata;

    assign full     = cmd_full;
    assign cmd_head = t_cmd'(cmd_rdata);
    assign o_result = t_result'(res_rdata);

    // Front: enable register and transaction classification
    msq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (cmd_full),
        .o_q_push    (cmd_push),
        .o_cmd       (front_cmd)
    );

    // Command queue between front and back
    msq_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (front_cmd),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_rdata),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    // Tone table
    msq_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Period divider
    msq_div #(
        .DIVIDEND (TICK_FREQ_HZ),
        .DW       (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Back: playback sequencer
    msq_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DW          (DW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_head),
        .i_cmd_empty    (cmd_empty),
        .o_cmd_pop      (cmd_pop),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_div_start    (div_start),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient),
        .o_res          (back_res),
        .o_res_push     (res_push),
        .i_res_full     (res_full)
    );

    // Result queue
    msq_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_full  (res_full),
        .o_empty (empty)
    );

endmodule

// File: hdl/msq_ram.sv
module msq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/msq_fifo.sv
module msq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // Pointer and fill-count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: hdl/msq_div.sv
module msq_div #(
    parameter int DIVIDEND = 1000000,
    parameter int DW = 20,
    localparam int CW = $clog2(DW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [15:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [15:0]   r_rem;
    logic [15:0]   r_dvs;
    logic [16:0]   rem_sh;
    logic [16:0]   rem_sub;
    logic          q_bit;

    // One restoring step: bring down the next dividend bit, try a subtract
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_bit   = (rem_sh >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: r_quo shifts dividend bits out and quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DW'(DIVIDEND);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/msq_front.sv
module msq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msq_pkg::t_item i_item,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_q_full,
    output logic           o_q_push,
    output msq_pkg::t_cmd  o_cmd
);

    import msq_pkg::*;

    logic r_enable;

    // Enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Classify the transaction; a start while disabled becomes a no-op
    always_comb begin
        o_cmd.entry_index   = i_item.entry_index;
        o_cmd.tone_freq     = i_item.tone_freq;
        o_cmd.tone_duration = i_item.tone_duration;
        unique case (i_item.mode)
            MODE_WRITE: o_cmd.op = OP_WRITE;
            MODE_START: o_cmd.op = r_enable ? OP_START : OP_NOP;
            MODE_TICK:  o_cmd.op = OP_TICK;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

    assign o_q_push = i_push && !i_q_full;

endmodule

// File: hdl/msq_back.sv
module msq_back #(
    parameter int TABLE_DEPTH = 64,
    parameter int DW = 20,
    localparam int PW = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msq_pkg::t_cmd    i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    output logic             o_ram_we,
    output logic [PW-1:0]    o_ram_waddr,
    output logic [31:0]      o_ram_wdata,
    output logic [PW-1:0]    o_ram_raddr,
    input  logic [31:0]      i_ram_rdata,
    output logic             o_div_start,
    output logic [15:0]      o_div_divisor,
    input  logic             i_div_done,
    input  logic [DW-1:0]    i_div_quotient,
    output msq_pkg::t_result o_res,
    output logic             o_res_push,
    input  logic             i_res_full
);

    import msq_pkg::*;

    localparam int RW = (DW > 20) ? DW : 20;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [PW-1:0] r_play_idx, n_play_idx;
    logic [15:0]   r_ticks, n_ticks;
    logic          r_active, n_active;
    logic [19:0]   r_reload, n_reload;
    logic [19:0]   r_compare, n_compare;
    logic [39:0]   r_prod, n_prod;

    logic [PW-1:0] idx_mod_lut [64];
    logic [PW-1:0] cmd_idx;
    logic [PW-1:0] next_idx;
    logic [15:0]   ticks_dec;
    logic [15:0]   e_freq;
    logic [15:0]   e_dur;
    logic [DW-1:0] period;
    logic [RW-1:0] rel_x;
    logic [19:0]   rel_sat;

    // Entry index reduced modulo the table depth
    for (genvar g = 0; g < 64; g++) begin : g_mod
        assign idx_mod_lut[g] = PW'(g % TABLE_DEPTH);
    end

    assign cmd_idx   = idx_mod_lut[r_cmd.entry_index];
    assign next_idx  = (r_play_idx == PW'(TABLE_DEPTH - 1)) ? '0 : r_play_idx + PW'(1);
    assign ticks_dec = (r_ticks != '0) ? r_ticks - 16'd1 : '0;
    assign e_freq    = i_ram_rdata[31:16];
    assign e_dur     = i_ram_rdata[15:0];

    // Reload from the quotient: max(q,1)-1, saturated to 20 bits
    assign period  = (i_div_quotient == '0) ? DW'(1) : i_div_quotient;
    assign rel_x   = RW'(period) - RW'(1);
    assign rel_sat = (rel_x > RW'(RELOAD_MAX)) ? RELOAD_MAX : rel_x[19:0];

    // Table write and read ports, divider operand
    assign o_ram_waddr = cmd_idx;
    assign o_ram_wdata = {r_cmd.tone_freq, r_cmd.tone_duration};
    assign o_ram_raddr = n_play_idx;
    assign o_div_divisor = e_freq;

    // Result fields come straight from the state registers
    assign o_res.pwm_reload    = r_reload;
    assign o_res.pwm_compare   = r_compare;
    assign o_res.playing       = r_active;
    assign o_res.current_index = 6'(r_play_idx);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_play_idx  = r_play_idx;
        n_ticks     = r_ticks;
        n_active    = r_active;
        n_reload    = r_reload;
        n_compare   = r_compare;
        n_prod      = r_prod;
        o_cmd_pop   = 1'b0;
        o_ram_we    = 1'b0;
        o_div_start = 1'b0;
        o_res_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                case (r_cmd.op)
                    OP_WRITE: begin
                        o_ram_we = 1'b1;
                    end
                    OP_START: begin
                        n_play_idx = cmd_idx;
                        n_state    = S_LOAD;
                    end
                    OP_TICK: begin
                        if (r_active) begin
                            n_ticks = ticks_dec;
                            if (ticks_dec == '0) begin
                                n_play_idx = next_idx;
                                n_state    = S_LOAD;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_LOAD: begin
                n_state = S_EMIT;
                if (e_freq == '0 && e_dur == '0) begin
                    // terminator: stop, silence the output
                    n_active  = 1'b0;
                    n_ticks   = '0;
                    n_compare = '0;
                end else begin
                    n_active = 1'b1;
                    n_ticks  = e_dur;
                    if (e_freq == '0) begin
                        n_compare = '0;
                    end else if (e_freq == FULL_DRIVE_FREQ) begin
                        n_reload  = FULL_DRIVE_RELOAD;
                        n_compare = FULL_DRIVE_RELOAD;
                    end else begin
                        o_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_reload = rel_sat;
                n_prod   = 40'(rel_sat) * 40'(DIV5_MUL);
                n_state  = S_DUTY;
            end
            S_DUTY: begin
                // 20 percent duty: floor(reload/5)
                n_compare = 20'(r_prod[39:DIV5_SHIFT]);
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_play_idx <= '0;
            r_ticks    <= '0;
            r_active   <= 1'b0;
            r_reload   <= FULL_DRIVE_RELOAD;
            r_compare  <= '0;
        end else begin
            r_state    <= n_state;
            r_play_idx <= n_play_idx;
            r_ticks    <= n_ticks;
            r_active   <= n_active;
            r_reload   <= n_reload;
            r_compare  <= n_compare;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_prod <= n_prod;
    end

endmodule
